// File: hdl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define ASSERT_IMPLY(name, ck, rn, ante, cons) \
    name: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// next-cycle implication, held off during reset
`define ASSERT_NEXT(name, ck, rn, ante, cons) \
    name: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

// File: hdl/hsv_pkg.sv
`default_nettype none

package hsv_pkg;

    localparam int FRAC_BITS_DEF = 15;
    localparam int CH_W          = 16;
    localparam int HUE_W         = 15;
    // wide enough for six times the channel spread
    localparam int NUM_W         = 19;

    typedef logic [CH_W-1:0]  chan_t;
    typedef logic [HUE_W-1:0] hue_t;
    typedef logic [NUM_W-1:0] num_t;

    typedef enum logic [2:0] {
        MAX_RED   = 3'b001,
        MAX_GREEN = 3'b010,
        MAX_BLUE  = 3'b100
    } max_sel_t;

    typedef struct packed {
        chan_t red;
        chan_t green;
        chan_t blue;
    } rgb_t;

    typedef struct packed {
        chan_t mx;
        chan_t delta;
        num_t  num;
        num_t  d6;
    } front_t;

endpackage

`default_nettype wire

// File: hdl/hsv_if.sv
`default_nettype none

interface hsv_rgb_if;
    import hsv_pkg::*;

    logic  valid;
    logic  ready;
    chan_t red;
    chan_t green;
    chan_t blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface hsv_res_if;
    import hsv_pkg::*;

    logic  valid;
    logic  ready;
    hue_t  hue;
    chan_t saturation;
    chan_t brightness;

    modport source (output valid, output hue, output saturation, output brightness,
                    input ready);
    modport sink   (input valid, input hue, input saturation, input brightness,
                    output ready);
endinterface

`default_nettype wire

// File: hdl/hsv_div.sv
`default_nettype none

// pipelined restoring divider, one quotient bit per stage
// quo = floor(num * 2^FRAC / den), valid when num <= den and den != 0
module hsv_div #(
    parameter int FRAC = hsv_pkg::FRAC_BITS_DEF,
    parameter int W    = hsv_pkg::CH_W
) (
    input  logic            clk,
    input  logic            en,
    input  logic [W-1:0]    num,
    input  logic [W-1:0]    den,
    output logic [FRAC:0]   quo
);

    localparam int QW = FRAC + 1;

    logic [W-1:0]  rem_reg [QW];
    logic [QW-1:0] quo_reg [QW];
    logic [W-1:0]  den_reg [QW-1];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [W-1:0]  rem_in;
        logic [W-1:0]  den_in;
        logic [QW-1:0] quo_in;
        logic          bit_in;
        logic [W:0]    trial;
        logic [W-1:0]  rem_next;
        logic [QW-1:0] quo_next;

        if (k == 0) begin : g_first
            // top dividend bits start the remainder, low bit of num shifts in first
            assign rem_in = num >> 1;
            assign den_in = den;
            assign quo_in = '0;
            assign bit_in = num[0];
        end else begin : g_rest
            assign rem_in = rem_reg[k-1];
            assign den_in = den_reg[k-1];
            assign quo_in = quo_reg[k-1];
            assign bit_in = 1'b0;
        end

        assign trial = {rem_in, bit_in};

        always_comb
        begin
            quo_next = quo_in;
            if (trial >= {1'b0, den_in})
            begin
                rem_next             = W'(trial - {1'b0, den_in});
                quo_next[QW-1-k]     = 1'b1;
            end
            else
            begin
                rem_next = W'(trial);
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= rem_next;
                quo_reg[k] <= quo_next;
            end
        end

        if (k < QW - 1) begin : g_den
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    den_reg[k] <= den_in;
                end
            end
        end
    end

    assign quo = quo_reg[QW-1];

endmodule

`default_nettype wire

// File: hdl/hsv_front.sv
`default_nettype none

// two stages: pick max and min, then spread, hue numerator and divisor
module hsv_front (
    input  logic            clk,
    input  logic            en,
    input  hsv_pkg::rgb_t   pix,
    output hsv_pkg::front_t res
);
    import hsv_pkg::*;

    rgb_t     pix_reg;
    chan_t    mx_reg;
    chan_t    mx_next;
    chan_t    mn_reg;
    chan_t    mn_next;
    max_sel_t sel_reg;
    max_sel_t sel_next;
    chan_t    delta;
    num_t     d_ext;
    num_t     d6;
    num_t     num_val;
    front_t   res_reg;
    front_t   res_next;

    // ties go to red, then green
    always_comb
    begin
        if (pix.red >= pix.green && pix.red >= pix.blue)
        begin
            sel_next = MAX_RED;
            mx_next  = pix.red;
        end
        else if (pix.green >= pix.blue)
        begin
            sel_next = MAX_GREEN;
            mx_next  = pix.green;
        end
        else
        begin
            sel_next = MAX_BLUE;
            mx_next  = pix.blue;
        end

        mn_next = pix.red;
        if (pix.green < mn_next)
        begin
            mn_next = pix.green;
        end
        if (pix.blue < mn_next)
        begin
            mn_next = pix.blue;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pix_reg <= pix;
            mx_reg  <= mx_next;
            mn_reg  <= mn_next;
            sel_reg <= sel_next;
        end
    end

    assign delta = mx_reg - mn_reg;
    assign d_ext = NUM_W'(delta);
    assign d6    = (d_ext << 2) + (d_ext << 1);

    always_comb
    begin
        case (sel_reg)
            MAX_RED:
            begin
                if (pix_reg.green >= pix_reg.blue)
                begin
                    num_val = NUM_W'(pix_reg.green) - NUM_W'(pix_reg.blue);
                end
                else
                begin
                    // wrap into the upper end of the circle
                    num_val = d6 - (NUM_W'(pix_reg.blue) - NUM_W'(pix_reg.green));
                end
            end
            MAX_GREEN:
            begin
                num_val = (d_ext << 1) + NUM_W'(pix_reg.blue) - NUM_W'(pix_reg.red);
            end
            MAX_BLUE:
            begin
                num_val = (d_ext << 2) + NUM_W'(pix_reg.red) - NUM_W'(pix_reg.green);
            end
            default:
            begin
                num_val = '0;
            end
        endcase
    end

    always_comb
    begin
        res_next.mx    = mx_reg;
        res_next.delta = delta;
        res_next.num   = num_val;
        res_next.d6    = d6;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

`default_nettype wire

// File: hdl/rgb_to_hsv_pixel_unit.sv
// rgb to hsv pixel converter
// pix_in carries one rgb item (red, green, blue, unsigned fractions with
// FRAC_BITS fraction bits); pix_out carries hue, saturation and brightness
// in the same format, hue truncated to 15 bits
// both channels use valid/ready: an item moves on a clock edge with both high
// the pipeline has two front stages (max/min, then spread and hue numerator),
// FRAC_BITS + 1 divider stages and one output register
// throughput is one item per cycle while the output is not stalled; each
// divider stage resolves one quotient bit with one compare and subtract, so a
// new item enters every cycle that the pipeline advances
// the whole pipeline advances together; it freezes only while the output
// register holds an item the receiver has not taken, and pix_in.ready drops
// for exactly those cycles, so nothing is lost or repeated under stall
// reset clears the valid bits only; the block is ready right after reset
`default_nettype none

module rgb_to_hsv_pixel_unit #(
    parameter int FRAC_BITS = hsv_pkg::FRAC_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    hsv_rgb_if.sink    pix_in,
    hsv_res_if.source  pix_out
);
    import hsv_pkg::*;

    // quotient bits per divider, and total pipeline depth
    localparam int QW  = FRAC_BITS + 1;
    localparam int LAT = QW + 3;

    logic           en;
    logic [LAT-1:0] vld_reg;
    logic [LAT-1:0] vld_next;
    rgb_t           pix;
    front_t         fr;
    logic [QW-1:0]  sat_q;
    logic [QW-1:0]  hue_q;

    // side data that rides along with the dividers
    chan_t          bri_pipe_reg [QW];
    logic [QW-1:0]  gray_pipe_reg;

    hue_t           hue_reg;
    hue_t           hue_next;
    chan_t          sat_reg;
    chan_t          sat_next;
    chan_t          bri_reg;

    // advance whenever the output slot is empty or being drained
    assign en           = !vld_reg[LAT-1] || pix_out.ready;
    assign pix_in.ready = en;

    assign vld_next = {vld_reg[LAT-2:0], pix_in.valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    assign pix = '{red: pix_in.red, green: pix_in.green, blue: pix_in.blue};

    hsv_front u_front (
        .clk (clk),
        .en  (en),
        .pix (pix),
        .res (fr)
    );

    // saturation: delta * one / max
    hsv_div #(
        .FRAC (FRAC_BITS),
        .W    (CH_W)
    ) u_sat_div (
        .clk (clk),
        .en  (en),
        .num (fr.delta),
        .den (fr.mx),
        .quo (sat_q)
    );

    // hue: num * one / (6 * delta)
    hsv_div #(
        .FRAC (FRAC_BITS),
        .W    (NUM_W)
    ) u_hue_div (
        .clk (clk),
        .en  (en),
        .num (fr.num),
        .den (fr.d6),
        .quo (hue_q)
    );

    // gray pixel (which covers black): spread is zero, divider outputs ignored
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            bri_pipe_reg[0] <= fr.mx;
            for (int i = 1; i < QW; i++)
            begin
                bri_pipe_reg[i] <= bri_pipe_reg[i-1];
            end
            gray_pipe_reg <= {gray_pipe_reg[QW-2:0], (fr.delta == '0)};
        end
    end

    // fields are masked to their port widths
    assign hue_next = gray_pipe_reg[QW-1] ? '0 : HUE_W'(hue_q);
    assign sat_next = gray_pipe_reg[QW-1] ? '0 : CH_W'(sat_q);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hue_reg <= hue_next;
            sat_reg <= sat_next;
            bri_reg <= bri_pipe_reg[QW-1];
        end
    end

    assign pix_out.valid      = vld_reg[LAT-1];
    assign pix_out.hue        = hue_reg;
    assign pix_out.saturation = sat_reg;
    assign pix_out.brightness = bri_reg;

endmodule

`default_nettype wire

// File: hdl/hsv_checker.sv
`default_nettype none
`include "assert_macros.svh"

module hsv_checker #(
    parameter int FRAC_BITS = hsv_pkg::FRAC_BITS_DEF
) (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [hsv_pkg::HUE_W-1:0]  hue,
    input logic [hsv_pkg::CH_W-1:0]   saturation,
    input logic [hsv_pkg::CH_W-1:0]   brightness
);

    localparam logic [31:0] ONE = 32'(1) << FRAC_BITS;

    logic [31:0]                                   sat_ext;
    logic [hsv_pkg::HUE_W+2*hsv_pkg::CH_W-1:0]     out_data;
    logic                                          out_zero;

    assign sat_ext  = 32'(saturation);
    assign out_data = {hue, saturation, brightness};
    assign out_zero = (saturation == '0) && (hue == '0);

    // a waiting item holds still
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))

    // an empty output slot never blocks the input
    `ASSERT_IMPLY(a_ready_when_empty, clk, rst_n, !out_valid, in_ready)

    // draining the output also frees the input
    `ASSERT_IMPLY(a_ready_on_drain, clk, rst_n, out_valid && out_ready, in_ready)

    // black pixel gives zero hue and saturation
    `ASSERT_IMPLY(a_black_pixel, clk, rst_n, out_valid && brightness == '0, out_zero)

    // saturation does not exceed one, checked while out_valid and in_valid are both high
    `ASSERT_IMPLY(a_sat_range, clk, rst_n, out_valid && in_valid, sat_ext <= ONE)

endmodule

bind rgb_to_hsv_pixel_unit hsv_checker #(
    .FRAC_BITS (FRAC_BITS)
) u_hsv_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (pix_in.valid),
    .in_ready   (pix_in.ready),
    .out_valid  (pix_out.valid),
    .out_ready  (pix_out.ready),
    .hue        (pix_out.hue),
    .saturation (pix_out.saturation),
    .brightness (pix_out.brightness)
);

`default_nettype wire
